/* rtl/lfl_pkg.sv */
// shared field widths and operation codes of the free list allocator
package lfl_pkg;

  localparam int FUNC_W = 3;
  localparam int PORT_W = 11;
  localparam int REQ_W  = 10;

  localparam logic [FUNC_W-1:0] FN_ALLOC   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_FREE1   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_FREEC   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_CLAIM   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_RELEASE = 3'd4;

endpackage

/* rtl/lfl_table.sv */
// next-pointer table: one write port, one read port with registered data
module lfl_table #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 11
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/linked_free_list_allocator_unit.sv */
// top level: free list sequencer over the next-pointer table
//
// A word is taken when start is high and busy is low. func selects the
// operation; the other input ports carry its operands. Exactly one result
// word follows per accepted word, on the result ports for one cycle while
// done is high; the receiver cannot stall, so nothing is held back.
// Free one and release make a single table write and no read; claim makes
// one table read; allocate of count entries and free chain of n entries
// make one table read per entry. Rejected operations read no table entry.
// The single table read port sets the pace: chain walks step one entry per
// cycle. busy is high while an operation is in flight, so a new word may
// start in the cycle its predecessor reports done.
// After reset the table is loaded with entry i pointing at i + 1, one entry
// per cycle, with busy high meanwhile.
module linked_free_list_allocator_unit
  import lfl_pkg::*;
#(
  parameter int ENTRIES = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [FUNC_W-1:0] func,
  input  logic [PORT_W-1:0] count,
  input  logic [REQ_W-1:0]  ref_req,
  input  logic [PORT_W-1:0] chain_head,
  input  logic [PORT_W-1:0] priv_head,
  output logic              done,
  output logic              status,
  output logic [PORT_W-1:0] ref_out,
  output logic [PORT_W-1:0] new_priv_head,
  output logic [PORT_W-1:0] free_count
);

  localparam int IW   = $clog2(ENTRIES);
  localparam int VW   = $clog2(ENTRIES + 2);
  localparam int TW   = (VW > PORT_W) ? VW : PORT_W;
  localparam int CNTW = $clog2(ENTRIES + 1);

  localparam logic [TW-1:0]   ENT   = TW'(ENTRIES);
  localparam logic [TW-1:0]   END_V = TW'(ENTRIES + 1);
  localparam logic [CNTW:0]   ENT_S = (CNTW + 1)'(ENTRIES);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC,
    S_FREE,
    S_CLAIM
  } state_t;

  state_t          state;
  logic [IW-1:0]   clr_idx;
  logic [TW-1:0]   fhead;
  logic [CNTW-1:0] ftotal;
  logic [TW-1:0]   pend;
  logic            pend_ok;
  logic [CNTW-1:0] left;
  logic [TW-1:0]   head_save;

  logic            rd_en;
  logic [IW-1:0]   rd_addr;
  logic [TW-1:0]   rd_data;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  logic [TW-1:0]   wr_data;

  logic [TW-1:0]   cnt_ext;
  logic [TW-1:0]   total_ext;
  logic [TW-1:0]   rreq_ext;
  logic [TW-1:0]   chd_ext;
  logic [TW-1:0]   phd_ext;
  logic [TW-1:0]   rd_val;
  logic            alloc_ok;
  logic            walk_more;
  logic [CNTW:0]   add_arg;
  logic [CNTW:0]   add_sum;
  logic [CNTW-1:0] add_sat;

  lfl_table #(
    .DEPTH (ENTRIES),
    .AW    (IW),
    .DW    (TW)
  ) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign busy       = (state != S_IDLE);
  assign cnt_ext    = TW'(count);
  assign total_ext  = TW'(ftotal);
  assign rreq_ext   = TW'(ref_req);
  assign chd_ext    = TW'(chain_head);
  assign phd_ext    = TW'(priv_head);
  assign free_count = total_ext[PORT_W-1:0];

  assign rd_val    = pend_ok ? rd_data : END_V;
  assign alloc_ok  = (cnt_ext != '0) && (cnt_ext <= total_ext);
  assign walk_more = (TW'(left) < ENT) && (rd_data < ENT);

  // saturating add onto the free count
  assign add_arg = (state == S_FREE) ? (CNTW + 1)'(left) : (CNTW + 1)'(1);
  assign add_sum = (CNTW + 1)'(ftotal) + add_arg;
  assign add_sat = (add_sum > ENT_S) ? CNTW'(ENTRIES) : add_sum[CNTW-1:0];

  // table port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx;
        wr_data = TW'(clr_idx) + TW'(1);
      end
      S_IDLE: begin
        if (start) begin
          unique case (func)
            FN_ALLOC: begin
              if (alloc_ok && (fhead < ENT)) begin
                rd_en   = 1'b1;
                rd_addr = fhead[IW-1:0];
              end
            end
            FN_FREE1: begin
              if (rreq_ext < ENT) begin
                wr_en   = 1'b1;
                wr_addr = rreq_ext[IW-1:0];
                wr_data = fhead;
              end
            end
            FN_FREEC: begin
              if (chd_ext < ENT) begin
                rd_en   = 1'b1;
                rd_addr = chd_ext[IW-1:0];
              end
            end
            FN_CLAIM: begin
              if (phd_ext < ENT) begin
                rd_en   = 1'b1;
                rd_addr = phd_ext[IW-1:0];
              end
            end
            FN_RELEASE: begin
              if (rreq_ext < ENT) begin
                wr_en   = 1'b1;
                wr_addr = rreq_ext[IW-1:0];
                wr_data = phd_ext;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ALLOC: begin
        if (left == '0) begin
          if (pend_ok) begin
            wr_en   = 1'b1;
            wr_addr = pend[IW-1:0];
            wr_data = END_V;
          end
        end else if (rd_val < ENT) begin
          rd_en   = 1'b1;
          rd_addr = rd_val[IW-1:0];
        end
      end
      S_FREE: begin
        if (walk_more) begin
          rd_en   = 1'b1;
          rd_addr = rd_data[IW-1:0];
        end else begin
          wr_en   = 1'b1;
          wr_addr = pend[IW-1:0];
          wr_data = fhead;
        end
      end
      S_CLAIM: begin
      end
      default: begin
      end
    endcase
  end

  // sequencer, list state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      done    <= 1'b0;
      fhead   <= '0;
      ftotal  <= CNTW'(ENTRIES);
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IW'(1);
          if (clr_idx == IW'(ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            status        <= 1'b1;
            ref_out       <= END_V[PORT_W-1:0];
            new_priv_head <= END_V[PORT_W-1:0];
            unique case (func)
              FN_ALLOC: begin
                if (alloc_ok) begin
                  ref_out <= fhead[PORT_W-1:0];
                  ftotal  <= ftotal - CNTW'(cnt_ext);
                  pend    <= fhead;
                  pend_ok <= (fhead < ENT);
                  left    <= CNTW'(cnt_ext - TW'(1));
                  state   <= S_ALLOC;
                end else begin
                  done <= 1'b1;
                end
              end
              FN_FREE1: begin
                if (rreq_ext < ENT) begin
                  fhead  <= rreq_ext;
                  ftotal <= add_sat;
                  status <= 1'b0;
                end
                done <= 1'b1;
              end
              FN_FREEC: begin
                if (chd_ext == END_V) begin
                  status <= 1'b0;
                  done   <= 1'b1;
                end else if (chd_ext < ENT) begin
                  pend      <= chd_ext;
                  head_save <= chd_ext;
                  left      <= CNTW'(1);
                  state     <= S_FREE;
                end else begin
                  done <= 1'b1;
                end
              end
              FN_CLAIM: begin
                new_priv_head <= priv_head;
                if (phd_ext < ENT) begin
                  ref_out <= priv_head;
                  status  <= 1'b0;
                  state   <= S_CLAIM;
                end else begin
                  done <= 1'b1;
                end
              end
              FN_RELEASE: begin
                new_priv_head <= priv_head;
                if (rreq_ext < ENT) begin
                  new_priv_head <= rreq_ext[PORT_W-1:0];
                  status        <= 1'b0;
                end
                done <= 1'b1;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_ALLOC: begin
          if (left == '0) begin
            fhead  <= rd_val;
            status <= 1'b0;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            pend    <= rd_val;
            pend_ok <= (rd_val < ENT);
            left    <= left - CNTW'(1);
          end
        end
        S_FREE: begin
          if (walk_more) begin
            pend <= rd_data;
            left <= left + CNTW'(1);
          end else begin
            fhead  <= head_save;
            ftotal <= add_sat;
            status <= 1'b0;
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_CLAIM: begin
          new_priv_head <= rd_data[PORT_W-1:0];
          done          <= 1'b1;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* tb/tb.sv */
// testbench for the free list allocator: directed and random words against a predictor
`timescale 1ns / 100ps

module tb;
  import lfl_pkg::*;

  localparam int ENTRIES = 1024;
  localparam logic [PORT_W-1:0] END_MARK = PORT_W'(ENTRIES + 1);
  localparam int CHK = 0;
  localparam int GEN = 1;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [PORT_W-1:0] count;
    logic [REQ_W-1:0]  ref_req;
    logic [PORT_W-1:0] chain_head;
    logic [PORT_W-1:0] priv_head;
  } op_word_t;

  typedef struct packed {
    logic              status;
    logic [PORT_W-1:0] ref_out;
    logic [PORT_W-1:0] new_priv_head;
    logic [PORT_W-1:0] free_count;
  } reply_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [FUNC_W-1:0] func = '0;
  logic [PORT_W-1:0] count = '0;
  logic [REQ_W-1:0]  ref_req = '0;
  logic [PORT_W-1:0] chain_head = '0;
  logic [PORT_W-1:0] priv_head = '0;
  logic              busy;
  logic              done;
  logic              status;
  logic [PORT_W-1:0] ref_out;
  logic [PORT_W-1:0] new_priv_head;
  logic [PORT_W-1:0] free_count;

  // two copies of the pool: one follows accepted words, one runs ahead for stimulus
  logic [PORT_W-1:0] link_tbl [0:1][0:ENTRIES-1];
  int                pool_head [0:1];
  int                pool_free [0:1];

  op_word_t          pending_ops [$];
  reply_t            predicted_replies [$];
  logic [PORT_W-1:0] held_chains [$];
  logic [PORT_W-1:0] owned_entries [$];
  logic [PORT_W-1:0] private_top = END_MARK;

  int  idle_pct = 25;
  bit  word_taken = 1'b0;
  int  stall_cycles = 0;
  int  mismatches = 0;
  int  replies_seen = 0;
  int  func_seen [0:7];

  linked_free_list_allocator_unit #(.ENTRIES(ENTRIES)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .count(count),
    .ref_req(ref_req),
    .chain_head(chain_head),
    .priv_head(priv_head),
    .done(done),
    .status(status),
    .ref_out(ref_out),
    .new_priv_head(new_priv_head),
    .free_count(free_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int next_of(int m, int idx);
    return (idx < ENTRIES) ? int'(link_tbl[m][idx]) : int'(END_MARK);
  endfunction

  function automatic reply_t run_pool_op(int m, op_word_t w);
    reply_t r;
    int cur;
    int n;
    r.status = 1'b1;
    r.ref_out = END_MARK;
    r.new_priv_head = END_MARK;
    case (w.func)
      FN_ALLOC: begin
        if (w.count != 0 && w.count <= pool_free[m]) begin
          cur = pool_head[m];
          r.ref_out = PORT_W'(cur);
          for (n = 1; n < w.count; n++) cur = next_of(m, cur);
          pool_head[m] = next_of(m, cur);
          if (cur < ENTRIES) link_tbl[m][cur] = END_MARK;
          pool_free[m] -= int'(w.count);
          r.status = 1'b0;
        end
      end
      FN_FREE1: begin
        if (w.ref_req < ENTRIES) begin
          link_tbl[m][w.ref_req] = PORT_W'(pool_head[m]);
          pool_head[m] = int'(w.ref_req);
          pool_free[m] = (pool_free[m] + 1 > ENTRIES) ? ENTRIES : pool_free[m] + 1;
          r.status = 1'b0;
        end
      end
      FN_FREEC: begin
        if (w.chain_head == END_MARK) begin
          r.status = 1'b0;
        end else if (w.chain_head < ENTRIES) begin
          cur = int'(w.chain_head);
          n = 1;
          while (n < ENTRIES && link_tbl[m][cur] < ENTRIES) begin
            cur = int'(link_tbl[m][cur]);
            n++;
          end
          link_tbl[m][cur] = PORT_W'(pool_head[m]);
          pool_head[m] = int'(w.chain_head);
          pool_free[m] = (pool_free[m] + n > ENTRIES) ? ENTRIES : pool_free[m] + n;
          r.status = 1'b0;
        end
      end
      FN_CLAIM: begin
        r.new_priv_head = w.priv_head;
        if (w.priv_head < ENTRIES) begin
          r.ref_out = w.priv_head;
          r.new_priv_head = link_tbl[m][int'(w.priv_head)];
          r.status = 1'b0;
        end
      end
      FN_RELEASE: begin
        r.new_priv_head = w.priv_head;
        if (w.ref_req < ENTRIES) begin
          link_tbl[m][w.ref_req] = w.priv_head;
          r.new_priv_head = PORT_W'(w.ref_req);
          r.status = 1'b0;
        end
      end
      default: ;
    endcase
    r.free_count = PORT_W'(pool_free[m]);
    return r;
  endfunction

  function automatic reply_t send(logic [FUNC_W-1:0] f, logic [PORT_W-1:0] cnt,
                                  logic [REQ_W-1:0] rr, logic [PORT_W-1:0] ch,
                                  logic [PORT_W-1:0] ph);
    op_word_t w;
    w.func = f;
    w.count = cnt;
    w.ref_req = rr;
    w.chain_head = ch;
    w.priv_head = ph;
    pending_ops.push_back(w);
    return run_pool_op(GEN, w);
  endfunction

  // an entry the caller owns: a claimed one, else the head of a held chain, else a random value
  function automatic logic [REQ_W-1:0] take_entry();
    int k;
    logic [PORT_W-1:0] h;
    if (owned_entries.size() > 0) begin
      h = owned_entries.pop_front();
      return h[REQ_W-1:0];
    end
    if (held_chains.size() == 0) return REQ_W'($urandom);
    k = $urandom_range(held_chains.size() - 1);
    h = held_chains[k];
    if (next_of(GEN, int'(h)) < ENTRIES) held_chains[k] = PORT_W'(next_of(GEN, int'(h)));
    else held_chains.delete(k);
    return h[REQ_W-1:0];
  endfunction

  task automatic gen_random();
    reply_t r;
    int pick;
    int k;
    int cnt;
    logic [PORT_W-1:0] h;
    pick = $urandom_range(99);
    if (pick < 10) begin
      r = send(FUNC_W'($urandom), PORT_W'($urandom), REQ_W'($urandom),
               PORT_W'($urandom), PORT_W'($urandom));
    end else if (pick < 35 || (held_chains.size() == 0 && owned_entries.size() == 0)) begin
      k = $urandom_range(99);
      if (k < 70) cnt = $urandom_range(6, 1);
      else if (k < 92) cnt = $urandom_range(40, 7);
      else if (k < 96) cnt = $urandom_range(300, 41);
      else cnt = pool_free[GEN] + $urandom_range(2, 0);
      r = send(FN_ALLOC, PORT_W'(cnt), REQ_W'($urandom), PORT_W'($urandom),
               PORT_W'($urandom));
      if (r.status == 1'b0 && r.ref_out < ENTRIES) held_chains.push_back(r.ref_out);
    end else if (pick < 55) begin
      if (held_chains.size() > 0) begin
        k = $urandom_range(held_chains.size() - 1);
        h = held_chains[k];
        held_chains.delete(k);
      end else begin
        h = END_MARK;
      end
      r = send(FN_FREEC, PORT_W'($urandom), REQ_W'($urandom), h, PORT_W'($urandom));
    end else if (pick < 70) begin
      r = send(FN_FREE1, PORT_W'($urandom), take_entry(), PORT_W'($urandom),
               PORT_W'($urandom));
    end else if (pick < 85) begin
      r = send(FN_RELEASE, PORT_W'($urandom), take_entry(), PORT_W'($urandom), private_top);
      private_top = r.new_priv_head;
    end else begin
      r = send(FN_CLAIM, PORT_W'($urandom), REQ_W'($urandom), PORT_W'($urandom),
               private_top);
      private_top = r.new_priv_head;
      if (r.status == 1'b0) owned_entries.push_back(r.ref_out);
    end
  endtask

  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pending_ops.size() != 0 || start || predicted_replies.size() != 0);
  endtask

  task automatic report(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || word_taken) begin
      if (pending_ops.size() > 0 && $urandom_range(99) >= idle_pct) begin
        func <= pending_ops[0].func;
        count <= pending_ops[0].count;
        ref_req <= pending_ops[0].ref_req;
        chain_head <= pending_ops[0].chain_head;
        priv_head <= pending_ops[0].priv_head;
        start <= 1'b1;
        void'(pending_ops.pop_front());
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_b
    op_word_t w;
    reply_t got;
    reply_t exp_r;
    if (rst) begin
      word_taken <= 1'b0;
      stall_cycles <= 0;
    end else begin
      word_taken <= start && !busy;
      if (start && !busy) begin
        w.func = func;
        w.count = count;
        w.ref_req = ref_req;
        w.chain_head = chain_head;
        w.priv_head = priv_head;
        predicted_replies.push_back(run_pool_op(CHK, w));
        func_seen[func]++;
      end
      if (done) begin
        replies_seen++;
        got.status = status;
        got.ref_out = ref_out;
        got.new_priv_head = new_priv_head;
        got.free_count = free_count;
        if (predicted_replies.size() == 0) begin
          report($sformatf("reply %0d with none pending: status %0d ref %0d head %0d free %0d",
                           replies_seen, got.status, got.ref_out, got.new_priv_head,
                           got.free_count));
        end else begin
          exp_r = predicted_replies.pop_front();
          if (got !== exp_r)
            report($sformatf({"reply %0d mismatch: expected status %0d ref %0d head %0d",
                              " free %0d, got status %0d ref %0d head %0d free %0d"},
                             replies_seen, exp_r.status, exp_r.ref_out,
                             exp_r.new_priv_head, exp_r.free_count, got.status,
                             got.ref_out, got.new_priv_head, got.free_count));
        end
      end
      if ((start && !busy) || done) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : stim_b
    reply_t r;
    int unused_seen;
    for (int m = 0; m < 2; m++) begin
      for (int i = 0; i < ENTRIES; i++) link_tbl[m][i] = PORT_W'(i + 1);
      pool_head[m] = 0;
      pool_free[m] = ENTRIES;
    end
    for (int f = 0; f < 8; f++) func_seen[f] = 0;

    void'(send(FN_ALLOC, '0, '0, '0, '0));
    void'(send(FN_ALLOC, 11'h7FF, 10'h3FF, 11'h7FF, 11'h7FF));
    r = send(FN_ALLOC, PORT_W'(ENTRIES), '0, '0, '0);
    void'(send(FN_ALLOC, PORT_W'(1), '0, '0, '0));
    void'(send(FN_CLAIM, '0, '0, '0, END_MARK));
    void'(send(FN_FREEC, '0, '0, r.ref_out, '0));
    void'(send(FN_FREEC, '0, '0, END_MARK, '0));
    void'(send(FN_FREEC, '0, '0, PORT_W'(ENTRIES), '0));
    void'(send(FN_FREEC, '0, '0, 11'h7FF, '0));
    void'(send(FN_FREE1, '0, 10'h3FF, '0, '0));
    void'(send(FN_CLAIM, '0, '0, '0, '0));
    r = send(FN_ALLOC, PORT_W'(3), '0, '0, '0);
    held_chains.push_back(r.ref_out);
    repeat (2) begin
      r = send(FN_RELEASE, '0, take_entry(), '0, private_top);
      private_top = r.new_priv_head;
    end
    repeat (3) begin
      r = send(FN_CLAIM, '0, '0, '0, private_top);
      private_top = r.new_priv_head;
      if (r.status == 1'b0) owned_entries.push_back(r.ref_out);
    end
    void'(send(FN_CLAIM, '0, '0, '0, 11'h7FF));
    void'(send(FN_CLAIM, '0, '0, '0, PORT_W'(ENTRIES)));
    void'(send(FN_RELEASE, '0, '0, '0, 11'h7FF));
    for (int k = 1; k <= 3; k++) void'(send(FUNC_W'(int'(FN_RELEASE) + k), '0, '0, '0, '0));
    void'(send(FN_FREE1, '0, take_entry(), '0, '0));
    void'(send(FN_FREEC, '0, '0, held_chains.size() > 0 ? held_chains.pop_front() : END_MARK,
               '0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    drain();

    idle_pct = 25;
    repeat (130) gen_random();
    drain();
    idle_pct = 66;
    repeat (130) gen_random();
    drain();
    idle_pct = 0;
    repeat (140) gen_random();
    drain();
    repeat (1100) @(posedge clk);

    unused_seen = 0;
    for (int f = int'(FN_RELEASE) + 1; f < 8; f++) unused_seen += func_seen[f];
    $display("covered words: %0d allocate, %0d free one, %0d free chain, %0d claim, %0d release",
             func_seen[FN_ALLOC], func_seen[FN_FREE1], func_seen[FN_FREEC],
             func_seen[FN_CLAIM], func_seen[FN_RELEASE]);
    $display("%0d unused code, %0d replies checked, %0d mismatches",
             unused_seen, replies_seen, mismatches);
    if (mismatches == 0 && predicted_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/lfl_pkg.sv
rtl/lfl_table.sv
rtl/linked_free_list_allocator_unit.sv
tb/tb.sv
